FILE: hdl/sche_pkg.sv
// Shared types, codes and the header text table for the Set-Cookie extractor.
`timescale 1ns / 1ps

package sche_pkg;

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_LINE  = 3'd1,
      PH_FOUND = 3'd2,
      PH_NAME  = 3'd3,
      PH_VALUE = 3'd4,
      PH_ENDED = 3'd5
   } phase_type;

   localparam logic [2:0] KIND_NAME    = 3'd0;
   localparam logic [2:0] KIND_VALUE   = 3'd1;
   localparam logic [2:0] KIND_COMMIT  = 3'd2;
   localparam logic [2:0] KIND_DISCARD = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;

   localparam logic [7:0] HDR_LEN = 8'd11;

   localparam logic [7:0] NAME_LIMIT_RESET  = 8'd50;
   localparam logic [7:0] VALUE_LIMIT_RESET = 8'd200;

   // Register indexes on the configuration port.
   localparam logic REG_NAME_LIMIT  = 1'b0;
   localparam logic REG_VALUE_LIMIT = 1'b1;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
   } event_type;

   // Characters of the text "Set-Cookie:"; positions past the end give zero.
   function automatic logic [7:0] hdr_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h53;
         4'd1:    c = 8'h65;
         4'd2:    c = 8'h74;
         4'd3:    c = 8'h2D;
         4'd4:    c = 8'h43;
         4'd5:    c = 8'h6F;
         4'd6:    c = 8'h6F;
         4'd7:    c = 8'h6B;
         4'd8:    c = 8'h69;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Control bytes: below space, or 0x80 and above.
   function automatic logic is_ctrl(input logic [7:0] b);
      return (b < CHAR_SPACE) || b[7];
   endfunction

endpackage

FILE: hdl/sche_parser.sv
// Front part: parser state machine that classifies each byte into at most one event.
`timescale 1ns / 1ps

module sche_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                start_req,
   input  logic [7:0]          name_limit,
   input  logic [7:0]          value_limit,
   output logic                evt_valid,
   output sche_pkg::event_type evt
);

   sche_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          count_ff, count_in;
   sche_pkg::phase_type cur_phase;
   logic [7:0]          cur_count;
   logic                start_discard;
   logic                term;

   // A new message restarts parsing before the byte is looked at.
   assign cur_phase     = start_req ? sche_pkg::PH_WAIT : phase_ff;
   assign cur_count     = start_req ? 8'd0 : count_ff;
   assign start_discard = start_req &&
                          (phase_ff == sche_pkg::PH_NAME || phase_ff == sche_pkg::PH_VALUE);
   assign term          = sche_pkg::is_ctrl(in_byte) || (in_byte == sche_pkg::CHAR_SEMI);

   // Next state.
   always_comb begin
      phase_in = cur_phase;
      count_in = cur_count;
      case (cur_phase)
         sche_pkg::PH_WAIT: begin
            if (in_byte == sche_pkg::CHAR_LF) begin
               phase_in = sche_pkg::PH_LINE;
               count_in = 8'd0;
            end
         end
         sche_pkg::PH_LINE: begin
            if (in_byte == sche_pkg::CHAR_LF) begin
               phase_in = sche_pkg::PH_ENDED;
               count_in = 8'd0;
            end else if (in_byte == sche_pkg::CHAR_CR) begin
               phase_in = cur_phase;
            end else if (cur_count >= sche_pkg::HDR_LEN ||
                         in_byte != sche_pkg::hdr_char(cur_count[3:0])) begin
               phase_in = sche_pkg::PH_WAIT;
               count_in = 8'd0;
            end else if (cur_count + 8'd1 == sche_pkg::HDR_LEN) begin
               phase_in = sche_pkg::PH_FOUND;
               count_in = 8'd0;
            end else begin
               count_in = cur_count + 8'd1;
            end
         end
         sche_pkg::PH_FOUND: begin
            if (in_byte == sche_pkg::CHAR_SPACE) begin
               phase_in = cur_phase;
            end else if (in_byte == sche_pkg::CHAR_LF) begin
               phase_in = sche_pkg::PH_LINE;
               count_in = 8'd0;
            end else if (in_byte < sche_pkg::CHAR_ZERO || in_byte[7] ||
                         in_byte == sche_pkg::CHAR_SEMI) begin
               phase_in = sche_pkg::PH_WAIT;
               count_in = 8'd0;
            end else begin
               phase_in = sche_pkg::PH_NAME;
               count_in = 8'd1;
            end
         end
         sche_pkg::PH_NAME: begin
            if (term) begin
               phase_in = (in_byte == sche_pkg::CHAR_LF) ? sche_pkg::PH_LINE
                                                         : sche_pkg::PH_WAIT;
               count_in = 8'd0;
            end else if (in_byte == sche_pkg::CHAR_EQ) begin
               phase_in = sche_pkg::PH_VALUE;
               count_in = 8'd0;
            end else if (cur_count >= name_limit) begin
               phase_in = sche_pkg::PH_WAIT;
               count_in = 8'd0;
            end else begin
               count_in = cur_count + 8'd1;
            end
         end
         sche_pkg::PH_VALUE: begin
            if (term) begin
               phase_in = (in_byte == sche_pkg::CHAR_LF) ? sche_pkg::PH_LINE
                                                         : sche_pkg::PH_WAIT;
               count_in = 8'd0;
            end else if (cur_count >= value_limit) begin
               phase_in = sche_pkg::PH_WAIT;
               count_in = 8'd0;
            end else begin
               count_in = cur_count + 8'd1;
            end
         end
         sche_pkg::PH_ENDED: begin
            phase_in = cur_phase;
         end
         default: begin
            phase_in = sche_pkg::PH_WAIT;
            count_in = 8'd0;
         end
      endcase
   end

   // Event produced by the byte.
   always_comb begin
      evt_valid = 1'b0;
      evt.kind  = sche_pkg::KIND_NAME;
      evt.data  = 8'd0;
      if (start_discard) begin
         evt_valid = 1'b1;
         evt.kind  = sche_pkg::KIND_DISCARD;
      end else begin
         case (cur_phase)
            sche_pkg::PH_LINE: begin
               if (in_byte == sche_pkg::CHAR_LF) begin
                  evt_valid = 1'b1;
                  evt.kind  = sche_pkg::KIND_END;
               end
            end
            sche_pkg::PH_FOUND: begin
               if (in_byte != sche_pkg::CHAR_SPACE && in_byte != sche_pkg::CHAR_LF &&
                   in_byte >= sche_pkg::CHAR_ZERO && !in_byte[7] &&
                   in_byte != sche_pkg::CHAR_SEMI) begin
                  evt_valid = 1'b1;
                  evt.kind  = sche_pkg::KIND_NAME;
                  evt.data  = in_byte;
               end
            end
            sche_pkg::PH_NAME: begin
               if (term) begin
                  evt_valid = 1'b1;
                  evt.kind  = sche_pkg::KIND_COMMIT;
               end else if (in_byte != sche_pkg::CHAR_EQ) begin
                  evt_valid = 1'b1;
                  if (cur_count >= name_limit) begin
                     evt.kind = sche_pkg::KIND_DISCARD;
                  end else begin
                     evt.kind = sche_pkg::KIND_NAME;
                     evt.data = in_byte;
                  end
               end
            end
            sche_pkg::PH_VALUE: begin
               evt_valid = 1'b1;
               if (term) begin
                  evt.kind = sche_pkg::KIND_COMMIT;
               end else if (cur_count >= value_limit) begin
                  evt.kind = sche_pkg::KIND_DISCARD;
               end else begin
                  evt.kind = sche_pkg::KIND_VALUE;
                  evt.data = in_byte;
               end
            end
            default: begin
               evt_valid = 1'b0;
            end
         endcase
      end
      evt_valid = evt_valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sche_pkg::PH_WAIT;
         count_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/sche_fifo.sv
// Short event queue between the parser and the output stage.
`timescale 1ns / 1ps

module sche_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sche_pkg::event_type push_data,
   input  logic                pop,
   output sche_pkg::event_type pop_data,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sche_pkg::event_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/sche_out.sv
// Back part: output register that drains the event queue onto the result channel.
`timescale 1ns / 1ps

module sche_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  sche_pkg::event_type q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_out_kind,
   output logic [7:0]          rsp_out_byte
);

   logic                valid_ff, valid_in;
   sche_pkg::event_type data_ff;

   // Load whenever the register is free or its item is being taken.
   assign q_pop = !q_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (valid_ff && rsp_stall) begin
         valid_in = 1'b1;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_data;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_kind = data_ff.kind;
   assign rsp_out_byte = data_ff.data;

endmodule

FILE: hdl/set_cookie_header_extractor_top.sv
// Top level of the Set-Cookie header extractor: parser, event queue, output stage, registers.
// Each event is written into the event queue when its byte is accepted, and is then loaded
// into the output register, from which the result channel takes it.
// Throughput: one byte per cycle while the event queue is not full; the parser state update is its own loop.
// Bytes that cause no event are still taken and produce nothing on the result channel.
// Input stalls only when the QUEUE_DEPTH-entry event queue is full.
// Synchronous active-high reset: parser waits for a newline, queue empties, limits 50 and 200.
`timescale 1ns / 1ps

module set_cookie_header_extractor_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel: one response byte per item.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_req,
   // Result channel: one event per item.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]          name_limit_ff, name_limit_in;
   logic [7:0]          value_limit_ff, value_limit_in;
   logic                csr_write;
   logic                req_accept;
   logic                evt_valid;
   sche_pkg::event_type evt;
   logic                q_full, q_empty, q_pop;
   sche_pkg::event_type q_data;

   // The configuration port never waits. Address bit 2 selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      name_limit_in  = name_limit_ff;
      value_limit_in = value_limit_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            sche_pkg::REG_NAME_LIMIT:  name_limit_in  = csr_pwdata[7:0];
            sche_pkg::REG_VALUE_LIMIT: value_limit_in = csr_pwdata[7:0];
            default:                   name_limit_in  = name_limit_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sche_pkg::REG_NAME_LIMIT:  csr_prdata = {24'd0, name_limit_ff};
         sche_pkg::REG_VALUE_LIMIT: csr_prdata = {24'd0, value_limit_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff  <= sche_pkg::NAME_LIMIT_RESET;
         value_limit_ff <= sche_pkg::VALUE_LIMIT_RESET;
      end else begin
         name_limit_ff  <= name_limit_in;
         value_limit_ff <= value_limit_in;
      end
   end

   // The parser takes a byte whenever the queue has room for its event, so
   // a stall on the result channel reaches the input only once the queue fills.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   sche_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .in_byte     (req_in_byte),
      .start_req   (req_start_req),
      .name_limit  (name_limit_ff),
      .value_limit (value_limit_ff),
      .evt_valid   (evt_valid),
      .evt         (evt)
   );

   sche_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_valid),
      .push_data (evt),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The output register holds an item while the consumer stalls and the
   // queue keeps filling behind it.
   sche_out u_out (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule
